/* src/swa_pkg.sv */
package swa_pkg;

    localparam int WIN_W     = 8;
    localparam int FRAC_BITS = 8;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 8'd100;

endpackage

/* src/swa_ring.sv */
module swa_ring #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/swa_div.sv */
module swa_div #(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_W       = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [SUM_W-1:0]              sum,
    input  logic [swa_pkg::WIN_W-1:0]     divisor,
    output logic                          done,
    output logic [SAMPLE_BITS+swa_pkg::FRAC_BITS-1:0] quotient
);

    import swa_pkg::*;

    localparam int AVG_W = SAMPLE_BITS + FRAC_BITS;
    localparam int CNT_W = $clog2(AVG_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [WIN_W-1:0] rem_reg;
    logic [WIN_W-1:0] rem_next;
    logic [AVG_W-1:0] acc_reg;
    logic [WIN_W-1:0] div_reg;
    logic [WIN_W:0]   trial;
    logic             qbit;

    always_comb
    begin
        trial = {rem_reg, acc_reg[AVG_W-1]};
        qbit  = trial >= {1'b0, div_reg};
        if (qbit)
        begin
            rem_next = WIN_W'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = trial[WIN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(AVG_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= WIN_W'(sum >> SAMPLE_BITS);
            acc_reg <= {sum[SAMPLE_BITS-1:0], {FRAC_BITS{1'b0}}};
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            acc_reg <= {acc_reg[AVG_W-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = acc_reg;

endmodule

/* src/sliding_window_average_core.sv */
// channel | direction | handshake              | payload
// --------+-----------+------------------------+---------------------
// in      | input     | in_valid / in_stall    | sample, first_of_set
// out     | output    | out_valid / out_stall  | average
// cfg     | input     | cfg_valid / cfg_ready  | window_len
//
// One sample at a time: each sample is taken in S_IDLE and updates the sum in S_READ;
// one that gives a result then waits in S_DIV for the bit-serial divider, which
// makes SAMPLE_BITS + 8 quotient bits, one quotient bit a cycle.
// Reset clears the pointer, fill count and sum and sets the window to 100.
// A finished result waits in the output register under out_stall while the
// next sample is taken; the divider holds its quotient if that register is busy.
module sliding_window_average_core #(
    parameter int MAX_WINDOW  = 128,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic [SAMPLE_BITS-1:0]                   sample,
    input  logic                                     first_of_set,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic [SAMPLE_BITS+swa_pkg::FRAC_BITS-1:0] average,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [swa_pkg::WIN_W-1:0]                window_len
);

    import swa_pkg::*;

    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW + 1);
    localparam int AVG_W = SAMPLE_BITS + FRAC_BITS;
    localparam int WMAX  = (MAX_WINDOW < 255) ? MAX_WINDOW : 255;
    localparam int AW    = ((PTR_W > WIN_W) ? PTR_W : WIN_W) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_HOLD
    } state_t;

    state_t           state_reg;
    logic [WIN_W-1:0] ws_reg;
    logic [PTR_W-1:0] wp_reg;
    logic [WIN_W-1:0] fill_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic             drop_reg;
    logic             emit_reg;
    logic             out_valid_reg;
    logic [AVG_W-1:0] average_reg;

    logic [WIN_W-1:0] w_eff;
    logic [WIN_W-1:0] fill_adj;
    logic [WIN_W-1:0] fill_next;
    logic             drop;
    logic [PTR_W-1:0] wp_next;
    logic [AW-1:0]    wp_ext;
    logic [AW-1:0]    w_ext;
    logic [AW-1:0]    old_ext;
    logic [PTR_W-1:0] oldest;
    logic [SUM_W-1:0] sum_next;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic             in_take;
    logic             cfg_take;
    logic             out_free;
    logic             out_load;
    logic             div_start;
    logic             div_done;
    logic [AVG_W-1:0] quotient;

    always_comb
    begin
        priority if (ws_reg == '0)
        begin
            w_eff = WIN_W'(1);
        end
        else if (int'(ws_reg) > WMAX)
        begin
            w_eff = WIN_W'(WMAX);
        end
        else
        begin
            w_eff = ws_reg;
        end
    end

    assign cfg_ready = (state_reg == S_IDLE);
    assign cfg_take  = cfg_valid && cfg_ready;
    assign in_stall  = (state_reg != S_IDLE) || cfg_valid;
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = (((state_reg == S_DIV) && div_done) || (state_reg == S_HOLD))
                     && out_free;

    assign fill_adj  = first_of_set ? '0 : fill_reg;
    assign drop      = fill_adj >= w_eff;
    assign fill_next = drop ? fill_adj : fill_adj + 1'b1;
    assign wp_next   = (wp_reg == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_reg + 1'b1;

    always_comb
    begin
        wp_ext = AW'(wp_reg);
        w_ext  = AW'(w_eff);
        if (wp_ext >= w_ext)
        begin
            old_ext = wp_ext - w_ext;
        end
        else
        begin
            old_ext = wp_ext + AW'(MAX_WINDOW) - w_ext;
        end
        oldest = old_ext[PTR_W-1:0];
    end

    assign sum_next  = sum_reg - (drop_reg ? SUM_W'(rd_data) : SUM_W'(0))
                     + SUM_W'(sample_reg);
    assign div_start = (state_reg == S_READ) && emit_reg;

    swa_ring #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (SAMPLE_BITS)
    ) u_ring (
        .clk     (clk),
        .wr_en   (in_take),
        .wr_addr (wp_reg),
        .wr_data (sample),
        .rd_en   (in_take),
        .rd_addr (oldest),
        .rd_data (rd_data)
    );

    swa_div #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .sum      (sum_next),
        .divisor  (w_eff),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ws_reg        <= WINDOW_RESET;
            wp_reg        <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            drop_reg      <= 1'b0;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_take)
                    begin
                        ws_reg   <= window_len;
                        fill_reg <= '0;
                        sum_reg  <= '0;
                    end
                    else if (in_take)
                    begin
                        sum_reg   <= first_of_set ? '0 : sum_reg;
                        fill_reg  <= fill_next;
                        wp_reg    <= wp_next;
                        drop_reg  <= drop;
                        emit_reg  <= fill_next >= w_eff;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    sum_reg   <= sum_next;
                    state_reg <= emit_reg ? S_DIV : S_IDLE;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= out_free ? S_IDLE : S_HOLD;
                    end
                end
                S_HOLD:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            average_reg <= quotient;
        end
        if (state_reg == S_IDLE && in_take)
        begin
            sample_reg <= sample;
        end
    end

    assign out_valid = out_valid_reg;
    assign average   = average_reg;

endmodule
